// ----- src/ows_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ows_pkg;

    localparam int unsigned ROM_W      = 64;
    localparam int unsigned ROM_BYTE_W = 8;
    localparam int unsigned BITNUM_W   = 7;
    localparam int unsigned POS_W      = 6;
    localparam logic [BITNUM_W-1:0] BIT_FIRST = 7'd1;
    localparam logic [BITNUM_W-1:0] BIT_END   = 7'd65;

    typedef enum logic [1:0] {
        CMD_START_FIRST = 2'd0,
        CMD_START_NEXT  = 2'd1,
        CMD_PRESENCE    = 2'd2,
        CMD_BIT_PAIR    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_RESET  = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_WRITE  = 2'd3
    } t_action;

    typedef struct packed {
        t_cmd cmd;
        logic presence;
        logic id_bit;
        logic id_comp;
    } t_item;

    typedef struct packed {
        t_action           bus_action;
        logic              write_value;
        logic              done_res;
        logic              found;
        logic [ROM_W-1:0]  rom_code;
    } t_result;

endpackage

`default_nettype wire

// ----- src/ows_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ows_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic       presence;
    logic       id_bit;
    logic       id_comp;

    modport source (output valid, cmd, presence, id_bit, id_comp, input ready);
    modport sink   (input valid, cmd, presence, id_bit, id_comp, output ready);
endinterface

`default_nettype wire

// ----- src/ows_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ows_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  bus_action;
    logic        write_value;
    logic        done_res;
    logic        found;
    logic [63:0] rom_code;

    modport source (output valid, bus_action, write_value, done_res, found, rom_code,
                    input ready);
    modport sink   (input valid, bus_action, write_value, done_res, found, rom_code,
                    output ready);
endinterface

`default_nettype wire

// ----- src/ows_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ows_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  ows_pkg::t_item  i_item,
    output ows_pkg::t_result o_result
);
    import ows_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESENCE = 2'd1,
        PH_BITS     = 2'd2
    } t_phase;

    logic [ROM_W-1:0]    r_rom_bits,  n_rom_bits;
    logic [BITNUM_W-1:0] r_last_disc, n_last_disc;
    logic                r_last_dev,  n_last_dev;
    logic [BITNUM_W-1:0] r_zero_fork, n_zero_fork;
    logic [BITNUM_W-1:0] r_bit_num,   n_bit_num;
    t_phase              r_phase,     n_phase;

    logic [POS_W-1:0]    w_pos;
    logic [BITNUM_W-1:0] w_bit_inc;
    logic                w_dir;
    t_result             w_res;

    assign w_pos     = r_bit_num[POS_W-1:0] - POS_W'(1);
    assign w_bit_inc = r_bit_num + BITNUM_W'(1);

    always_comb begin
        n_rom_bits  = r_rom_bits;
        n_last_disc = r_last_disc;
        n_last_dev  = r_last_dev;
        n_zero_fork = r_zero_fork;
        n_bit_num   = r_bit_num;
        n_phase     = r_phase;
        w_dir       = 1'b0;
        w_res.bus_action  = ACT_NONE;
        w_res.write_value = 1'b0;
        w_res.done_res    = 1'b0;
        w_res.found       = 1'b0;

        unique case (i_item.cmd)
            CMD_START_FIRST, CMD_START_NEXT: begin
                n_bit_num   = BIT_FIRST;
                n_zero_fork = '0;
                if (i_item.cmd == CMD_START_FIRST) begin
                    n_last_disc = '0;
                    n_last_dev  = 1'b0;
                end
                if (n_last_dev) begin
                    // all devices walked: report no device and rearm
                    n_last_disc    = '0;
                    n_last_dev     = 1'b0;
                    n_phase        = PH_IDLE;
                    w_res.done_res = 1'b1;
                end else begin
                    n_phase          = PH_PRESENCE;
                    w_res.bus_action = ACT_RESET;
                end
            end
            CMD_PRESENCE: begin
                if (r_phase == PH_PRESENCE) begin
                    if (!i_item.presence) begin
                        n_last_disc    = '0;
                        n_last_dev     = 1'b0;
                        n_phase        = PH_IDLE;
                        w_res.done_res = 1'b1;
                    end else begin
                        n_phase          = PH_BITS;
                        w_res.bus_action = ACT_SEARCH;
                    end
                end
            end
            CMD_BIT_PAIR: begin
                if (r_phase == PH_BITS && r_bit_num != '0 && r_bit_num < BIT_END) begin
                    if (i_item.id_bit && i_item.id_comp) begin
                        n_last_disc    = '0;
                        n_last_dev     = 1'b0;
                        n_phase        = PH_IDLE;
                        w_res.done_res = 1'b1;
                    end else begin
                        if (i_item.id_bit != i_item.id_comp) begin
                            w_dir = i_item.id_bit;
                        end else begin
                            // discrepancy: follow the earlier path, flip at the last one
                            if (r_bit_num < r_last_disc) begin
                                w_dir = r_rom_bits[w_pos];
                            end else begin
                                w_dir = (r_bit_num == r_last_disc);
                            end
                            if (!w_dir) begin
                                n_zero_fork = r_bit_num;
                            end
                        end
                        n_rom_bits[w_pos] = w_dir;
                        n_bit_num         = w_bit_inc;
                        w_res.bus_action  = ACT_WRITE;
                        w_res.write_value = w_dir;
                        if (w_bit_inc == BIT_END) begin
                            n_last_disc    = n_zero_fork;
                            n_last_dev     = r_last_dev | (n_zero_fork == '0);
                            n_phase        = PH_IDLE;
                            w_res.done_res = 1'b1;
                            w_res.found    = 1'b1;
                            if (n_rom_bits[ROM_BYTE_W-1:0] == '0) begin
                                n_last_disc = '0;
                                n_last_dev  = 1'b0;
                                w_res.found = 1'b0;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        w_res.rom_code = n_rom_bits;
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bits  <= '0;
            r_last_disc <= '0;
            r_last_dev  <= 1'b0;
            r_zero_fork <= '0;
            r_bit_num   <= BIT_FIRST;
            r_phase     <= PH_IDLE;
        end else if (i_advance) begin
            r_rom_bits  <= n_rom_bits;
            r_last_disc <= n_last_disc;
            r_last_dev  <= n_last_dev;
            r_zero_fork <= n_zero_fork;
            r_bit_num   <= n_bit_num;
            r_phase     <= n_phase;
        end
    end

endmodule

`default_nettype wire

// ----- src/one_wire_rom_search.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Port   Fields
// -------  ---  -----  ------------------------------------------------------
// command  in   i_in   cmd, presence, id_bit, id_comp
// result   out  o_out  bus_action, write_value, done_res, found, rom_code
//
// One word in, one word out; an accepted word is held in the input register,
// and its result is held in the result register that drives o_out.
// Throughput is one word per cycle while o_out.ready does not stall: the input
// register, the decision logic and the result register form a two-stage pipe.
// Synchronous active-low reset clears the search state and both valid flags.
// A stalled result holds the pipe; the input register still takes one word.
module one_wire_rom_search (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ows_in_if.sink    i_in,
    ows_out_if.source o_out
);
    import ows_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_res;
    logic    w_advance;
    t_result w_result;

    assign w_advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    ows_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_in_item),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item.cmd      <= t_cmd'(i_in.cmd);
            r_in_item.presence <= i_in.presence;
            r_in_item.id_bit   <= i_in.id_bit;
            r_in_item.id_comp  <= i_in.id_comp;
        end
        if (w_advance) begin
            r_out_res <= w_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.bus_action  = r_out_res.bus_action;
    assign o_out.write_value = r_out_res.write_value;
    assign o_out.done_res    = r_out_res.done_res;
    assign o_out.found       = r_out_res.found;
    assign o_out.rom_code    = r_out_res.rom_code;

endmodule

`default_nettype wire

// ----- sim/one_wire_rom_search_tb.sv -----
`timescale 1ns / 1ps

import ows_pkg::*;

typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRESENCE = 2'd1,
    PH_BITS     = 2'd2
} t_search_phase;

class ows_search_scoreboard;
    logic [ROM_W-1:0]    rom_bits;
    logic [BITNUM_W-1:0] last_disc;
    logic [BITNUM_W-1:0] zero_fork;
    logic [BITNUM_W-1:0] bit_num;
    logic                last_dev;
    logic                dir_taken;
    t_search_phase       phase;
    t_result             expected_q[$];
    int unsigned         errors;

    function new();
        rom_bits  = '0;
        last_disc = '0;
        zero_fork = '0;
        bit_num   = BIT_FIRST;
        last_dev  = 1'b0;
        dir_taken = 1'b0;
        phase     = PH_IDLE;
        errors    = 0;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    // Work out the result word caused by one accepted command word.
    function void note_word(t_item w);
        t_result             r;
        logic [POS_W-1:0]    pos;
        logic                dir;
        r = '0;
        case (w.cmd)
            CMD_START_FIRST, CMD_START_NEXT: begin
                if (w.cmd == CMD_START_FIRST) begin
                    last_disc = '0;
                    last_dev  = 1'b0;
                end
                bit_num   = BIT_FIRST;
                zero_fork = '0;
                if (last_dev) begin
                    // start after the last device: report no device, wipe history
                    last_disc  = '0;
                    last_dev   = 1'b0;
                    phase      = PH_IDLE;
                    r.done_res = 1'b1;
                end else begin
                    phase        = PH_PRESENCE;
                    r.bus_action = ACT_RESET;
                end
            end
            CMD_PRESENCE: begin
                if (phase == PH_PRESENCE) begin
                    if (!w.presence) begin
                        last_disc  = '0;
                        last_dev   = 1'b0;
                        phase      = PH_IDLE;
                        r.done_res = 1'b1;
                    end else begin
                        phase        = PH_BITS;
                        r.bus_action = ACT_SEARCH;
                    end
                end
            end
            default: begin
                if (phase == PH_BITS && bit_num >= BIT_FIRST && bit_num < BIT_END) begin
                    if (w.id_bit && w.id_comp) begin
                        // nobody answered the slot
                        last_disc  = '0;
                        last_dev   = 1'b0;
                        phase      = PH_IDLE;
                        r.done_res = 1'b1;
                    end else begin
                        pos = POS_W'(bit_num - 7'd1);
                        if (w.id_bit != w.id_comp) begin
                            dir = w.id_bit;
                        end else begin
                            if (bit_num < last_disc)
                                dir = rom_bits[pos];
                            else
                                dir = (bit_num == last_disc);
                            if (!dir)
                                zero_fork = bit_num;
                        end
                        rom_bits[pos] = dir;
                        dir_taken     = dir;
                        bit_num       = bit_num + 7'd1;
                        r.bus_action  = ACT_WRITE;
                        r.write_value = dir;
                        if (bit_num >= BIT_END) begin
                            r.done_res = 1'b1;
                            r.found    = 1'b1;
                            last_disc  = zero_fork;
                            if (last_disc == '0)
                                last_dev = 1'b1;
                            // a zero family byte counts as a failed pass
                            if (rom_bits[ROM_BYTE_W-1:0] == '0) begin
                                last_disc = '0;
                                last_dev  = 1'b0;
                                r.found   = 1'b0;
                            end
                            phase = PH_IDLE;
                        end
                    end
                end
            end
        endcase
        r.rom_code = rom_bits;
        expected_q.push_back(r);
    endfunction

    function void flag_field(string name, logic [ROM_W-1:0] exp_v, logic [ROM_W-1:0] act_v);
        if (act_v !== exp_v) begin
            errors++;
            if (errors <= 30)
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        end
    endfunction

    function void check_word(t_result got);
        t_result exp_r;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 30)
                $error("result word with nothing expected, rom_code 0x%0h", got.rom_code);
            return;
        end
        exp_r = expected_q.pop_front();
        flag_field("bus_action", ROM_W'(exp_r.bus_action), ROM_W'(got.bus_action));
        flag_field("write_value", ROM_W'(exp_r.write_value), ROM_W'(got.write_value));
        flag_field("done_res", ROM_W'(exp_r.done_res), ROM_W'(got.done_res));
        flag_field("found", ROM_W'(exp_r.found), ROM_W'(got.found));
        flag_field("rom_code", exp_r.rom_code, got.rom_code);
    endfunction
endclass

module one_wire_rom_search_tb;

    localparam int unsigned STUCK_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned WORD_TARGET = 900;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ows_in_if  in_if ();
    ows_out_if out_if ();

    one_wire_rom_search u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    ows_search_scoreboard sb = new();

    int unsigned sender_idle_pct = 0;
    int unsigned stall_pct       = 0;
    int unsigned words_sent      = 0;
    int unsigned hold_left       = 0;
    int unsigned stuck_cycles    = 0;
    bit          hold_req        = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_word(t_cmd c, logic p, logic b, logic cb);
        t_item       w;
        int unsigned gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        w.cmd      = c;
        w.presence = p;
        w.id_bit   = b;
        w.id_comp  = cb;
        in_if.valid    <= 1'b1;
        in_if.cmd      <= c;
        in_if.presence <= p;
        in_if.id_bit   <= b;
        in_if.id_comp  <= cb;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_word(w);
        words_sent++;
    endtask

    // Stop offering and let every outstanding result drain.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Result side: check accepted words, drive ready with random stalls and
    // the occasional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                t_result got;
                got.bus_action  = t_action'(out_if.bus_action);
                got.write_value = out_if.write_value;
                got.done_res    = out_if.done_res;
                got.found       = out_if.found;
                got.rom_code    = out_if.rom_code;
                sb.check_word(got);
            end
            if (hold_left != 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        logic [ROM_W-1:0] bus_dev [8];
        logic [7:0]       alive;
        logic [ROM_W-1:0] base;
        logic             rd_bit;
        logic             rd_cmp;
        logic             pres;
        int unsigned      bus_idx;
        int unsigned      ndev;
        int unsigned      pass_no;
        int unsigned      bit_no;
        int unsigned      noise;

        i_rst_n        <= 1'b0;
        in_if.valid    <= 1'b0;
        in_if.cmd      <= CMD_START_FIRST;
        in_if.presence <= 1'b0;
        in_if.id_bit   <= 1'b0;
        in_if.id_comp  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: wrong-phase words, no presence, open slot, abort mid-pass
        send_word(CMD_PRESENCE, 1'b1, 1'b0, 1'b1);
        send_word(CMD_BIT_PAIR, 1'b0, 1'b1, 1'b0);
        send_word(CMD_START_NEXT, 1'b1, 1'b1, 1'b1);
        send_word(CMD_BIT_PAIR, 1'b1, 1'b0, 1'b1);
        send_word(CMD_PRESENCE, 1'b0, 1'b1, 1'b1);
        send_word(CMD_START_FIRST, 1'b0, 1'b0, 1'b0);
        send_word(CMD_PRESENCE, 1'b1, 1'b0, 1'b0);
        send_word(CMD_PRESENCE, 1'b1, 1'b1, 1'b0);
        send_word(CMD_BIT_PAIR, 1'b0, 1'b0, 1'b1);
        send_word(CMD_BIT_PAIR, 1'b1, 1'b1, 1'b0);
        send_word(CMD_BIT_PAIR, 1'b0, 1'b0, 1'b0);
        send_word(CMD_BIT_PAIR, 1'b0, 1'b1, 1'b1);
        send_word(CMD_START_FIRST, 1'b1, 1'b0, 1'b1);
        send_word(CMD_PRESENCE, 1'b1, 1'b0, 1'b0);
        send_word(CMD_BIT_PAIR, 1'b1, 1'b0, 1'b0);
        send_word(CMD_START_NEXT, 1'b0, 1'b0, 1'b0);
        send_word(CMD_PRESENCE, 1'b1, 1'b1, 1'b1);
        send_word(CMD_BIT_PAIR, 1'b0, 1'b0, 1'b0);
        send_word(CMD_BIT_PAIR, 1'b1, 1'b1, 1'b1);
        wait_drained();

        // random: walk a simulated bus of devices through full enumerations
        bus_idx = 0;
        while (words_sent < WORD_TARGET) begin
            case (bus_idx % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 52; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 52; end
                default: begin sender_idle_pct = 7; stall_pct = 7; end
            endcase
            if (bus_idx == 1)
                hold_req = 1'b1;

            base = {$urandom, $urandom};
            if (bus_idx == 1 || $urandom_range(5) == 0)
                base[ROM_BYTE_W-1:0] = '0;
            if (bus_idx == 0) begin
                ndev = 1;
                if (base[ROM_BYTE_W-1:0] == '0)
                    base[0] = 1'b1;
            end else if (bus_idx == 2) begin
                ndev = 0;
            end else begin
                ndev = $urandom_range(1, 5);
            end
            for (int d = 0; d < 8; d++) begin
                bus_dev[d] = base;
                if (d != 0)
                    repeat ($urandom_range(1, 3))
                        bus_dev[d][6'($urandom_range(63))] ^= 1'b1;
            end

            for (pass_no = 0; pass_no < ndev + 2; pass_no++) begin
                if ($urandom_range(15) == 0)
                    send_word(CMD_BIT_PAIR, 1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                send_word(pass_no == 0 ? CMD_START_FIRST : CMD_START_NEXT,
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
                if (sb.phase == PH_IDLE)
                    break;
                pres = (ndev != 0) ? ($urandom_range(19) != 0) : 1'($urandom_range(1));
                send_word(CMD_PRESENCE, pres, 1'($urandom_range(1)),
                          1'($urandom_range(1)));
                if (sb.phase != PH_BITS)
                    continue;
                alive = (8'd1 << ndev) - 8'd1;
                for (bit_no = 1; bit_no <= 64; bit_no++) begin
                    noise = $urandom_range(999);
                    if (noise == 0) begin
                        send_word(CMD_PRESENCE, 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 1'($urandom_range(1)));
                    end else if (noise == 1) begin
                        send_word(CMD_BIT_PAIR, 1'($urandom_range(1)), 1'b1, 1'b1);
                        break;
                    end else if (noise == 2) begin
                        break;
                    end
                    rd_bit = 1'b1;
                    rd_cmp = 1'b1;
                    for (int d = 0; d < 8; d++) begin
                        if (alive[d]) begin
                            rd_bit &= bus_dev[d][bit_no-1];
                            rd_cmp &= ~bus_dev[d][bit_no-1];
                        end
                    end
                    send_word(CMD_BIT_PAIR, 1'($urandom_range(1)), rd_bit, rd_cmp);
                    if (sb.phase != PH_BITS && bit_no != 64)
                        break;
                    // drop devices that lost the direction just written
                    for (int d = 0; d < 8; d++)
                        if (bus_dev[d][bit_no-1] != sb.dir_taken)
                            alive[d] = 1'b0;
                end
            end
            wait_drained();
            bus_idx++;
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
